// ===== src/sha1_stream_hasher_core_macros.svh =====
// ---------------------------------------------------------------------------
// sha1 stream hasher assertion macros
// shared assertion forms, clocked on clk and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef SHA1_STREAM_HASHER_CORE_MACROS_SVH
`define SHA1_STREAM_HASHER_CORE_MACROS_SVH

// consequent must hold in the same cycle
`define SHA1SH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SHA1SH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sha1sh_pkg.sv =====
// ---------------------------------------------------------------------------
// sha1sh_pkg
// shared constants, command and status types of the sha1 stream hasher
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha1sh_pkg;

  // initial chaining value
  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hefcdab89;
  localparam logic [31:0] H2_INIT = 32'h98badcfe;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hc3d2e1f0;

  // round constants
  localparam logic [31:0] K_CH   = 32'h5a827999;
  localparam logic [31:0] K_PAR0 = 32'h6ed9eba1;
  localparam logic [31:0] K_MAJ  = 32'h8f1bbcdc;
  localparam logic [31:0] K_PAR1 = 32'hca62c1d6;

  // padding marker byte
  localparam logic [7:0] PAD_MARK = 8'h80;

  // byte positions inside a 64-byte block
  localparam logic [5:0] POS_LAST = 6'd63;
  localparam logic [5:0] POS_LEN  = 6'd56;

  // round counter limits
  localparam logic [6:0] RND_LAST = 7'd79;
  localparam logic [6:0] RND_PAR0 = 7'd20;
  localparam logic [6:0] RND_MAJ  = 7'd40;
  localparam logic [6:0] RND_PAR1 = 7'd60;

  // source of the byte written into the block
  typedef enum logic [1:0] {
    SEL_MSG,
    SEL_MARK,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  // round function group
  typedef enum logic [1:0] {
    GRP_CH,
    GRP_PAR0,
    GRP_MAJ,
    GRP_PAR1
  } rnd_grp_t;

  // controller to datapath commands
  typedef struct packed {
    logic      byte_we;
    byte_sel_t byte_sel;
    logic      msg_count;
    logic      load_work;
    logic      round_step;
    rnd_grp_t  grp;
    logic      chain_add;
    logic      chain_init;
    logic      out_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [5:0] pos;
  } dp_sts_t;

endpackage

// ===== src/sha1_stream_hasher_core.sv =====
// ------- sha1_stream_hasher_core: byte-serial sha-1 engine -------
// item: every 64th byte also starts 80 rounds plus 1 chaining add
// in_ready stays low while the single shared round unit works on a block
// last item: pad bytes up to block end, rounds and add per block, then load
// sync reset: chaining value to initial hash, length zero, no result pending
// ------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1_stream_hasher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word0,
  output logic [31:0] out_digest_word1,
  output logic [31:0] out_digest_word2,
  output logic [31:0] out_digest_word3,
  output logic [31:0] out_digest_word4
);

  `include "sha1_stream_hasher_core_macros.svh"

  sha1sh_pkg::dp_cmd_t cmd;
  sha1sh_pkg::dp_sts_t sts;

  // sequencer
  sha1sh_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte_present (in_byte_present),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cmd             (cmd),
    .sts             (sts)
  );

  // hashing datapath
  sha1sh_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data_byte (in_data_byte),
    .cmd          (cmd),
    .sts          (sts),
    .digest_word0 (out_digest_word0),
    .digest_word1 (out_digest_word1),
    .digest_word2 (out_digest_word2),
    .digest_word3 (out_digest_word3),
    .digest_word4 (out_digest_word4)
  );

  // checks on controller and datapath cooperation
  `SHA1SH_ASSERT_NOW(a_out_load_free, cmd.out_load, !out_valid || out_ready, "result overwritten")
  `SHA1SH_ASSERT_NEXT(a_block_wrap, cmd.load_work, sts.pos == 6'd0, "no position wrap")
  `SHA1SH_ASSERT_NOW(a_idle_take, in_ready, !cmd.round_step && !cmd.chain_add, "busy while ready")

endmodule

// ===== src/sha1sh_ctrl.sv =====
// ---------------------------------------------------------------------------
// sha1sh_ctrl
// sequencer for byte loading, padding, 80 rounds, chaining add and digest out
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1sh_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_byte_present,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output sha1sh_pkg::dp_cmd_t cmd,
  input  sha1sh_pkg::dp_sts_t sts
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ROUND  = 3'd1;
  localparam logic [2:0] ST_ADD    = 3'd2;
  localparam logic [2:0] ST_PAD    = 3'd3;
  localparam logic [2:0] ST_DIGEST = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [6:0] rnd_r, rnd_nxt;
  logic       in_pad_r, in_pad_nxt;
  logic       pad_first_r, pad_first_nxt;
  logic       len_ok_r, len_ok_nxt;
  logic       pad_done_r, pad_done_nxt;
  logic       out_valid_r, out_valid_nxt;

  // next state and command decode
  always_comb begin
    sha1sh_pkg::byte_sel_t pad_sel;
    pad_sel       = sha1sh_pkg::SEL_ZERO;
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    in_pad_nxt    = in_pad_r;
    pad_first_nxt = pad_first_r;
    len_ok_nxt    = len_ok_r;
    pad_done_nxt  = pad_done_r;
    cmd           = '0;
    cmd.byte_sel  = sha1sh_pkg::SEL_MSG;
    cmd.grp       = sha1sh_pkg::GRP_CH;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_byte_present) begin
            cmd.byte_we   = 1'b1;
            cmd.msg_count = 1'b1;
          end
          if (in_last) begin
            in_pad_nxt    = 1'b1;
            pad_first_nxt = 1'b1;
            len_ok_nxt    = 1'b0;
            pad_done_nxt  = 1'b0;
          end
          if (in_byte_present && sts.pos == sha1sh_pkg::POS_LAST) begin
            cmd.load_work = 1'b1;
            state_nxt     = ST_ROUND;
          end else if (in_last) begin
            state_nxt = ST_PAD;
          end
        end
      end

      ST_ROUND: begin
        cmd.round_step = 1'b1;
        if (rnd_r < sha1sh_pkg::RND_PAR0) begin
          cmd.grp = sha1sh_pkg::GRP_CH;
        end else if (rnd_r < sha1sh_pkg::RND_MAJ) begin
          cmd.grp = sha1sh_pkg::GRP_PAR0;
        end else if (rnd_r < sha1sh_pkg::RND_PAR1) begin
          cmd.grp = sha1sh_pkg::GRP_MAJ;
        end else begin
          cmd.grp = sha1sh_pkg::GRP_PAR1;
        end
        if (rnd_r == sha1sh_pkg::RND_LAST) begin
          rnd_nxt   = '0;
          state_nxt = ST_ADD;
        end else begin
          rnd_nxt = rnd_r + 7'd1;
        end
      end

      ST_ADD: begin
        cmd.chain_add = 1'b1;
        if (!in_pad_r) begin
          state_nxt = ST_IDLE;
        end else if (pad_done_r) begin
          state_nxt = ST_DIGEST;
        end else begin
          state_nxt = ST_PAD;
        end
      end

      ST_PAD: begin
        // marker first, length only in the block that ends the message
        if (pad_first_r) begin
          pad_sel = sha1sh_pkg::SEL_MARK;
        end else if (len_ok_r && sts.pos >= sha1sh_pkg::POS_LEN) begin
          pad_sel = sha1sh_pkg::SEL_LEN;
        end else begin
          pad_sel = sha1sh_pkg::SEL_ZERO;
        end
        cmd.byte_we   = 1'b1;
        cmd.byte_sel  = pad_sel;
        pad_first_nxt = 1'b0;
        if (pad_first_r && sts.pos < sha1sh_pkg::POS_LEN) begin
          len_ok_nxt = 1'b1;
        end
        if (sts.pos == sha1sh_pkg::POS_LAST) begin
          cmd.load_work = 1'b1;
          len_ok_nxt    = 1'b1;
          state_nxt     = ST_ROUND;
          if (pad_sel == sha1sh_pkg::SEL_LEN) begin
            pad_done_nxt = 1'b1;
          end
        end
      end

      ST_DIGEST: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load   = 1'b1;
          cmd.chain_init = 1'b1;
          in_pad_nxt     = 1'b0;
          pad_first_nxt  = 1'b0;
          len_ok_nxt     = 1'b0;
          pad_done_nxt   = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      in_pad_r    <= 1'b0;
      pad_first_r <= 1'b0;
      len_ok_r    <= 1'b0;
      pad_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      in_pad_r    <= in_pad_nxt;
      pad_first_r <= pad_first_nxt;
      len_ok_r    <= len_ok_nxt;
      pad_done_r  <= pad_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== src/sha1sh_dp.sv =====
// ---------------------------------------------------------------------------
// sha1sh_dp
// byte packer, rolling schedule window, round unit, chaining value, digest
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1sh_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_data_byte,
  input  sha1sh_pkg::dp_cmd_t cmd,
  output sha1sh_pkg::dp_sts_t sts,
  output logic [31:0]         digest_word0,
  output logic [31:0]         digest_word1,
  output logic [31:0]         digest_word2,
  output logic [31:0]         digest_word3,
  output logic [31:0]         digest_word4
);

  logic [23:0] acc_r, acc_nxt;
  logic [31:0] win_r [16];
  logic [31:0] win_nxt [16];
  logic [5:0]  pos_r, pos_nxt;
  logic [60:0] cnt_r, cnt_nxt;
  logic [31:0] wk_r [5];
  logic [31:0] wk_nxt [5];
  logic [31:0] h_r [5];
  logic [31:0] h_nxt [5];
  logic [31:0] dig_r [5];
  logic [31:0] dig_nxt [5];

  logic [63:0] len_bits;
  logic [7:0]  byte_val;
  logic [31:0] sched_word;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] tmp_val;

  assign len_bits = {cnt_r, 3'b000};

  // byte source
  always_comb begin
    case (cmd.byte_sel)
      sha1sh_pkg::SEL_MSG:  byte_val = in_data_byte;
      sha1sh_pkg::SEL_MARK: byte_val = sha1sh_pkg::PAD_MARK;
      sha1sh_pkg::SEL_ZERO: byte_val = 8'h00;
      default:              byte_val = len_bits[{~pos_r[2:0], 3'b000} +: 8];
    endcase
  end

  // next schedule word from the window taps
  always_comb begin
    logic [31:0] x;
    x          = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
    sched_word = {x[30:0], x[31]};
  end

  // round function and constant
  always_comb begin
    case (cmd.grp)
      sha1sh_pkg::GRP_CH: begin
        f_val = (wk_r[1] & wk_r[2]) | (~wk_r[1] & wk_r[3]);
        k_val = sha1sh_pkg::K_CH;
      end
      sha1sh_pkg::GRP_PAR0: begin
        f_val = wk_r[1] ^ wk_r[2] ^ wk_r[3];
        k_val = sha1sh_pkg::K_PAR0;
      end
      sha1sh_pkg::GRP_MAJ: begin
        f_val = (wk_r[1] & wk_r[2]) | (wk_r[1] & wk_r[3]) | (wk_r[2] & wk_r[3]);
        k_val = sha1sh_pkg::K_MAJ;
      end
      default: begin
        f_val = wk_r[1] ^ wk_r[2] ^ wk_r[3];
        k_val = sha1sh_pkg::K_PAR1;
      end
    endcase
    tmp_val = {wk_r[0][26:0], wk_r[0][31:27]} + f_val + wk_r[4] + k_val + win_r[0];
  end

  // byte packing and schedule window
  always_comb begin
    acc_nxt = acc_r;
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    for (int i = 0; i < 16; i++) begin
      win_nxt[i] = win_r[i];
    end
    if (cmd.byte_we) begin
      acc_nxt = {acc_r[15:0], byte_val};
      pos_nxt = pos_r + 6'd1;
      if (pos_r[1:0] == 2'b11) begin
        for (int i = 0; i < 15; i++) begin
          win_nxt[i] = win_r[i + 1];
        end
        win_nxt[15] = {acc_r, byte_val};
      end
    end else if (cmd.round_step) begin
      for (int i = 0; i < 15; i++) begin
        win_nxt[i] = win_r[i + 1];
      end
      win_nxt[15] = sched_word;
    end
    if (cmd.msg_count) begin
      cnt_nxt = cnt_r + 61'd1;
    end
    if (cmd.chain_init) begin
      pos_nxt = '0;
      cnt_nxt = '0;
    end
  end

  // working registers, chaining value and digest
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      wk_nxt[i]  = wk_r[i];
      h_nxt[i]   = h_r[i];
      dig_nxt[i] = dig_r[i];
    end
    if (cmd.load_work) begin
      for (int i = 0; i < 5; i++) begin
        wk_nxt[i] = h_r[i];
      end
    end else if (cmd.round_step) begin
      wk_nxt[4] = wk_r[3];
      wk_nxt[3] = wk_r[2];
      wk_nxt[2] = {wk_r[1][1:0], wk_r[1][31:2]};
      wk_nxt[1] = wk_r[0];
      wk_nxt[0] = tmp_val;
    end
    if (cmd.chain_add) begin
      for (int i = 0; i < 5; i++) begin
        h_nxt[i] = h_r[i] + wk_r[i];
      end
    end
    if (cmd.out_load) begin
      for (int i = 0; i < 5; i++) begin
        dig_nxt[i] = h_r[i];
      end
    end
    if (cmd.chain_init) begin
      h_nxt[0] = sha1sh_pkg::H0_INIT;
      h_nxt[1] = sha1sh_pkg::H1_INIT;
      h_nxt[2] = sha1sh_pkg::H2_INIT;
      h_nxt[3] = sha1sh_pkg::H3_INIT;
      h_nxt[4] = sha1sh_pkg::H4_INIT;
    end
  end

  // registers with reset: position, length and chaining value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      cnt_r  <= '0;
      h_r[0] <= sha1sh_pkg::H0_INIT;
      h_r[1] <= sha1sh_pkg::H1_INIT;
      h_r[2] <= sha1sh_pkg::H2_INIT;
      h_r[3] <= sha1sh_pkg::H3_INIT;
      h_r[4] <= sha1sh_pkg::H4_INIT;
    end else begin
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
      for (int i = 0; i < 5; i++) begin
        h_r[i] <= h_nxt[i];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    for (int i = 0; i < 16; i++) begin
      win_r[i] <= win_nxt[i];
    end
    for (int i = 0; i < 5; i++) begin
      wk_r[i]  <= wk_nxt[i];
      dig_r[i] <= dig_nxt[i];
    end
  end

  assign sts.pos      = pos_r;
  assign digest_word0 = dig_r[0];
  assign digest_word1 = dig_r[1];
  assign digest_word2 = dig_r[2];
  assign digest_word3 = dig_r[3];
  assign digest_word4 = dig_r[4];

endmodule
